>>> design/sid_pkg.sv
package sid_pkg;

  // Default operand and quotient width.
  localparam int unsigned DATA_WIDTH = 32;

  // Control bits that travel with each request along the cell chain.
  typedef struct packed {
    logic valid;  // stage holds a request
    logic neg;    // quotient must be negated at the end
    logic sat;    // divide by zero or overflow, quotient forced to max positive
  } sid_ctrl_t;

endpackage

>>> design/sid_req_if.sv
interface sid_req_if #(
  parameter int unsigned W = sid_pkg::DATA_WIDTH
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] dividend;
  logic signed [W-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink (input valid, input dividend, input divisor, output ready);
endinterface

>>> design/sid_rsp_if.sv
interface sid_rsp_if #(
  parameter int unsigned W = sid_pkg::DATA_WIDTH
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] quotient;
  logic                saturated;

  modport source (output valid, output quotient, output saturated, input ready);
  modport sink (input valid, input quotient, input saturated, output ready);
endinterface

>>> design/signed_int_divider_top.sv
// Signed integer divider, quotient truncated toward zero.
//
// Requests arrive on req_i (dividend, divisor) and results leave on rsp_o
// (quotient, saturated), both valid/ready channels; a request is taken at a
// clock edge where valid and ready are both high. A zero divisor, or the most
// negative dividend over minus one, gives the largest positive quotient with
// saturated set.
//
// The request is registered as operand magnitudes, then walks through a chain
// of DATA_WIDTH division cells, one quotient bit per cell, and the sign fix is
// applied into the output register. The chain is fully pipelined, so a new
// request can be taken every cycle while the output is not stalled, and up to
// DATA_WIDTH + 2 requests are in flight.
//
// The whole chain advances only when the output register is empty or being
// read; while a result waits on a stalled receiver, every stage holds and
// req_i.ready is low. Reset clears all stage valid bits; no request is in
// flight afterwards.
module signed_int_divider_top #(
  parameter int unsigned DATA_WIDTH = sid_pkg::DATA_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sid_req_if.sink    req_i,
  sid_rsp_if.source  rsp_o
);

  localparam int unsigned W = DATA_WIDTH;
  localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MinNeg = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MinusOne = {W{1'b1}};
  localparam logic [W-1:0] One = {{(W-1){1'b0}}, 1'b1};

  logic adv;

  sid_pkg::sid_ctrl_t ctrl_s [0:W];
  logic [W-1:0]       rem_s  [0:W];
  logic [W-1:0]       num_s  [0:W];
  logic [W-1:0]       quo_s  [0:W];
  logic [W-1:0]       den_s  [0:W];

  sid_pkg::sid_ctrl_t ctrl0_d;
  sid_pkg::sid_ctrl_t ctrl0_q;
  logic [W-1:0]       num0_d, den0_d, num0_q, den0_q;
  logic               a_neg, b_neg;

  logic               out_valid_q;
  logic [W-1:0]       out_quo_d, out_quo_q;
  logic               out_sat_q;

  // The chain moves as one whenever the output register can take a result.
  assign adv         = ~out_valid_q | rsp_o.ready;
  assign req_i.ready = adv;

  // Input stage: magnitudes, sign of the quotient and the saturating cases.
  always_comb begin
    a_neg         = req_i.dividend[W-1];
    b_neg         = req_i.divisor[W-1];
    num0_d        = a_neg ? (~req_i.dividend) + One : req_i.dividend;
    den0_d        = b_neg ? (~req_i.divisor) + One : req_i.divisor;
    ctrl0_d.valid = req_i.valid;
    ctrl0_d.neg   = a_neg ^ b_neg;
    ctrl0_d.sat   = (req_i.divisor == '0) ||
                    ((req_i.dividend == MinNeg) && (req_i.divisor == MinusOne));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl0_q <= '0;
    end else if (adv) begin
      ctrl0_q <= ctrl0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num0_q <= num0_d;
      den0_q <= den0_d;
    end
  end

  assign ctrl_s[0] = ctrl0_q;
  assign rem_s[0]  = '0;
  assign num_s[0]  = num0_q;
  assign quo_s[0]  = '0;
  assign den_s[0]  = den0_q;

  // Chain of division cells, most significant quotient bit first.
  for (genvar k = 0; k < W; k++) begin : g_cell
    sid_cell #(
      .W (W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .ctrl_i (ctrl_s[k]),
      .rem_i  (rem_s[k]),
      .num_i  (num_s[k]),
      .quo_i  (quo_s[k]),
      .den_i  (den_s[k]),
      .ctrl_o (ctrl_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .num_o  (num_s[k+1]),
      .quo_o  (quo_s[k+1]),
      .den_o  (den_s[k+1])
    );
  end

  // Sign fix and saturation into the output register.
  always_comb begin
    if (ctrl_s[W].sat) begin
      out_quo_d = MaxPos;
    end else if (ctrl_s[W].neg) begin
      out_quo_d = (~quo_s[W]) + One;
    end else begin
      out_quo_d = quo_s[W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ctrl_s[W].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_quo_q <= out_quo_d;
      out_sat_q <= ctrl_s[W].sat;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.quotient  = out_quo_q;
  assign rsp_o.saturated = out_sat_q;

  // A saturated result always carries the largest positive quotient.
  a_sat_maxpos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_sat_q) |-> (out_quo_q == MaxPos))
    else $error("saturated result without max positive quotient");

  // A taken request shows up in the input stage on the next cycle.
  a_req_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> ctrl0_q.valid)
    else $error("accepted request lost at the input stage");

  // A request leaving the last cell is never dropped on its way out.
  a_no_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && ctrl_s[W].valid) |=> out_valid_q)
    else $error("request dropped between the chain and the output register");

  // While the receiver stalls, the last cell holds its request.
  a_chain_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv && ctrl_s[W].valid) |=> (ctrl_s[W].valid && $stable(quo_s[W])))
    else $error("cell chain moved during a stall");

endmodule

>>> design/sid_cell.sv
// One restoring division step: brings down the next dividend bit, tries to
// subtract the divisor and shifts the resulting quotient bit in.
module sid_cell #(
  parameter int unsigned W = sid_pkg::DATA_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  sid_pkg::sid_ctrl_t ctrl_i,
  input  logic [W-1:0]      rem_i,
  input  logic [W-1:0]      num_i,
  input  logic [W-1:0]      quo_i,
  input  logic [W-1:0]      den_i,
  output sid_pkg::sid_ctrl_t ctrl_o,
  output logic [W-1:0]      rem_o,
  output logic [W-1:0]      num_o,
  output logic [W-1:0]      quo_o,
  output logic [W-1:0]      den_o
);

  logic [W:0]   rem_sh;
  logic [W:0]   diff;
  logic         fits;
  logic [W-1:0] rem_d;

  // The partial remainder stays below the divisor, so the shifted value never
  // exceeds W bits and the top bit of the difference is the borrow.
  always_comb begin
    rem_sh = {rem_i, num_i[W-1]};
    diff   = rem_sh - {1'b0, den_i};
    fits   = ~diff[W];
    rem_d  = fits ? diff[W-1:0] : rem_sh[W-1:0];
  end

  // Control state is reset; the data path only moves with its request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_o <= '0;
    end else if (en_i) begin
      ctrl_o <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      num_o <= {num_i[W-2:0], 1'b0};
      quo_o <= {quo_i[W-2:0], fits};
      den_o <= den_i;
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

// Expected quotient and flag for one request.
typedef struct {
  logic signed [sid_pkg::DATA_WIDTH-1:0] quotient;
  logic                                  saturated;
} quotient_rsp_t;

// Predicts each division and compares results in arrival order.
class quotient_board;
  localparam int unsigned W = sid_pkg::DATA_WIDTH;
  localparam logic signed [W-1:0] MOST_NEG = {1'b1, {(W - 1){1'b0}}};
  localparam logic signed [W-1:0] MOST_POS = {1'b0, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0] MINUS_ONE = '1;

  quotient_rsp_t expected_quotients[$];
  int unsigned   mismatch_count;

  function new();
    mismatch_count = 0;
  endfunction

  // Work out the quotient of an accepted request and queue it.
  function void note_request(logic signed [W-1:0] dividend, logic signed [W-1:0] divisor);
    quotient_rsp_t exp_rsp;
    logic [W:0]    mag_n;
    logic [W:0]    mag_d;
    logic [W:0]    rem;
    logic [W-1:0]  q;
    if (divisor == '0 || (dividend == MOST_NEG && divisor == MINUS_ONE)) begin
      exp_rsp.quotient  = MOST_POS;
      exp_rsp.saturated = 1'b1;
    end else begin
      // Magnitudes carry one extra bit so the most negative value is exact.
      mag_n = dividend[W-1] ? (~{dividend[W-1], dividend} + 1'b1) : {1'b0, dividend};
      mag_d = divisor[W-1] ? (~{divisor[W-1], divisor} + 1'b1) : {1'b0, divisor};
      rem = '0;
      q   = '0;
      // Restoring division, most significant quotient bit first.
      for (int i = W - 1; i >= 0; i--) begin
        rem = {rem[W-1:0], mag_n[i]};
        q   = q << 1;
        if (rem >= mag_d) begin
          rem  = rem - mag_d;
          q[0] = 1'b1;
        end
      end
      if (dividend[W-1] != divisor[W-1]) begin
        q = ~q + 1'b1;
      end
      exp_rsp.quotient  = q;
      exp_rsp.saturated = 1'b0;
    end
    expected_quotients.push_back(exp_rsp);
  endfunction

  // Compare an accepted result against the oldest prediction.
  function void check_result(logic signed [W-1:0] quotient, logic saturated);
    quotient_rsp_t exp_rsp;
    if (expected_quotients.size() == 0) begin
      $error("result with no request pending: quotient %0d, saturated %0d",
             quotient, saturated);
      mismatch_count++;
    end else begin
      exp_rsp = expected_quotients.pop_front();
      if (quotient !== exp_rsp.quotient) begin
        $error("quotient: expected %0d, actual %0d", exp_rsp.quotient, quotient);
        mismatch_count++;
      end
      if (saturated !== exp_rsp.saturated) begin
        $error("saturated: expected %0d, actual %0d", exp_rsp.saturated, saturated);
        mismatch_count++;
      end
    end
  endfunction

  function int unsigned pending();
    return expected_quotients.size();
  endfunction
endclass

module testbench;
  localparam int unsigned W = sid_pkg::DATA_WIDTH;
  localparam int unsigned LATENCY = W + 2;
  localparam int unsigned RANDOM_REQUESTS = 1800;
  localparam int unsigned CALM_REQUESTS = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic signed [W-1:0] MOST_NEG = {1'b1, {(W - 1){1'b0}}};
  localparam logic signed [W-1:0] MOST_POS = {1'b0, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0] MINUS_ONE = '1;

  logic          clk_i;
  logic          rst_ni;
  logic          idle_enabled;
  int unsigned   quiet_cycles = 0;
  quotient_board board;

  sid_req_if #(.W(W)) req_if ();
  sid_rsp_if #(.W(W)) rsp_if ();

  signed_int_divider_top #(
    .DATA_WIDTH(W)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Free-running 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Predict every request taken by the block.
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      board.note_request(req_if.dividend, req_if.divisor);
    end
  end

  // Check every result taken from the block.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      board.check_result(rsp_if.quotient, rsp_if.saturated);
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL signed_int_divider_top");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: accepts results, stalling in short random bursts.
  initial begin
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (idle_enabled && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  // Present one request and hold it until the block takes it.
  task automatic send_request(input logic signed [W-1:0] dividend,
                              input logic signed [W-1:0] divisor);
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.dividend <= dividend;
    req_if.divisor  <= divisor;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // Operand with a spread of magnitudes, signs and edge values.
  function automatic logic signed [W-1:0] shaped_operand();
    logic signed [W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2:    v = v >>> $urandom_range(0, W - 1);
      3:    v = $signed($urandom_range(0, 40)) - 20;
      4: begin
        case ($urandom_range(0, 5))
          0:       v = '0;
          1:       v = 1;
          2:       v = MINUS_ONE;
          3:       v = MOST_NEG;
          4:       v = MOST_POS;
          default: v = MOST_NEG + 1;
        endcase
      end
      default: v = $signed({1'b0, {(W - 1){1'b1}}} >> $urandom_range(0, W - 1))
                   ^ ($urandom_range(0, 1) ? MINUS_ONE : '0);
    endcase
    return v;
  endfunction

  initial begin
    logic signed [W-1:0] dividend;
    logic signed [W-1:0] divisor;
    board           = new();
    idle_enabled    = 1'b1;
    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.dividend <= '0;
    req_if.divisor  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests: sign combinations, extremes and both saturating cases.
    send_request(0, 1);
    send_request(1, 0);
    send_request(0, 0);
    send_request(MOST_NEG, 0);
    send_request(MOST_POS, 0);
    send_request(MOST_NEG, MINUS_ONE);
    send_request(MOST_NEG, 1);
    send_request(MOST_NEG, MOST_NEG);
    send_request(MOST_POS, MOST_NEG);
    send_request(MOST_POS, MINUS_ONE);
    send_request(MOST_POS, MOST_POS);
    send_request(MINUS_ONE, MOST_NEG);
    send_request(MOST_NEG, 2);
    send_request(MOST_NEG + 1, MINUS_ONE);
    send_request(1, MOST_POS);
    send_request(7, 2);
    send_request(-7, 2);
    send_request(7, -2);
    send_request(-7, -2);
    send_request(MINUS_ONE, 1);
    send_request(MOST_POS, 1);
    send_request(5, 7);

    // Random requests; the last stretch runs without idling on either side.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS - CALM_REQUESTS) begin
        idle_enabled = 1'b0;
      end
      if ($urandom_range(0, 2) == 0) begin
        dividend = $urandom;
        divisor  = $urandom;
      end else begin
        dividend = shaped_operand();
        divisor  = shaped_operand();
      end
      if ($urandom_range(0, 49) == 0) begin
        dividend = MOST_NEG;
        divisor  = MINUS_ONE;
      end
      send_request(dividend, divisor);
    end
    req_if.valid <= 1'b0;

    // Drain the pipeline, then allow a little extra time for stray results.
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);

    if (board.mismatch_count == 0 && board.pending() == 0) begin
      $display("PASS signed_int_divider_top");
    end else begin
      $display("FAIL signed_int_divider_top");
    end
    $finish;
  end
endmodule

>>> filelist.f
design/sid_pkg.sv
design/sid_req_if.sv
design/sid_rsp_if.sv
design/sid_cell.sv
design/signed_int_divider_top.sv
verif/testbench.sv
